FILE: rtl/blink_pattern_generator_assert.svh
// Assertion macros for the blink pattern generator, clocked on clk and disabled in reset.
`ifndef BLINK_PATTERN_GENERATOR_ASSERT_SVH
`define BLINK_PATTERN_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define BPG_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("blink pattern generator: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define BPG_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("blink pattern generator: next-cycle check failed");

`else

`define BPG_ASSERT_ALWAYS(label, cond)
`define BPG_ASSERT_NEXT(label, trig, cond)

`endif

`endif

FILE: rtl/bpg_pkg.sv
// Shared types, codes and preset tables of the blink pattern generator.
`default_nettype none

package bpg_pkg;

	localparam int TIMER_W = 11;
	localparam int REPS_W  = 8;

	localparam logic [TIMER_W-1:0] TIMER_MAX = 11'd2047;
	localparam logic [REPS_W-1:0]  ENDLESS   = 8'hFF;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	localparam logic KIND_VIBRATOR = 1'b0;
	localparam logic KIND_LED      = 1'b1;

	typedef struct packed {
		logic [TIMER_W-1:0] timer;
		logic               on_phase;
		logic               running;
		logic [REPS_W-1:0]  repeat_count;
		logic [1:0]         pattern_index;
	} state_t;

	// On time in milliseconds of each preset.
	function automatic logic [TIMER_W-1:0] on_ms(input logic kind, input logic [1:0] idx);
		logic [TIMER_W-1:0] v;
		case (idx)
			2'd0:    v = 11'd25;
			2'd1:    v = (kind == KIND_LED) ? 11'd175 : 11'd700;
			2'd2:    v = (kind == KIND_LED) ? 11'd175 : 11'd400;
			default: v = 11'd100;
		endcase
		return v;
	endfunction

	// Off time in milliseconds of each preset.
	function automatic logic [TIMER_W-1:0] off_ms(input logic kind, input logic [1:0] idx);
		logic [TIMER_W-1:0] v;
		case (idx)
			2'd0:    v = 11'd1975;
			2'd1:    v = (kind == KIND_LED) ? 11'd200 : 11'd300;
			2'd2:    v = (kind == KIND_LED) ? 11'd200 : 11'd250;
			default: v = 11'd900;
		endcase
		return v;
	endfunction

	// Number of on bursts of each preset.
	function automatic logic [REPS_W-1:0] preset_reps(input logic kind, input logic [1:0] idx);
		logic [REPS_W-1:0] v;
		case (idx)
			2'd0:    v = ENDLESS;
			2'd1:    v = (kind == KIND_LED) ? 8'd2 : 8'd1;
			2'd2:    v = (kind == KIND_LED) ? 8'd10 : 8'd2;
			default: v = 8'd180;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bpg_cmd_if.sv
// Request channel carrying mode and pattern into the generator.
`default_nettype none

interface bpg_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [1:0] pattern;

	modport source (output valid, output mode, output pattern, input ready);
	modport sink   (input valid, input mode, input pattern, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpg_res_if.sv
// Result channel carrying pin level, busy flag and remaining repeats.
`default_nettype none

interface bpg_res_if;
	logic       valid;
	logic       ready;
	logic       pin_level;
	logic       busy_res;
	logic [7:0] repeats_left;

	modport source (output valid, output pin_level, output busy_res, output repeats_left,
		input ready);
	modport sink   (input valid, input pin_level, input busy_res, input repeats_left,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/bpg_step.sv
// Next-state logic of the blink pattern generator for one request.
`default_nettype none

module bpg_step (
	input  bpg_pkg::state_t cur,
	input  logic [1:0]      mode,
	input  logic [1:0]      pattern,
	input  logic            kind,
	output bpg_pkg::state_t nxt
);
	import bpg_pkg::*;

	logic [TIMER_W-1:0] timer_inc;
	logic [TIMER_W-1:0] on_lim;
	logic [TIMER_W-1:0] off_lim;
	logic [REPS_W-1:0]  reps_dec;

	assign timer_inc = (cur.timer < TIMER_MAX) ? cur.timer + 1'b1 : cur.timer;
	assign on_lim    = on_ms(kind, cur.pattern_index);
	assign off_lim   = off_ms(kind, cur.pattern_index);
	assign reps_dec  = (cur.repeat_count != '0) ? cur.repeat_count - 1'b1 : cur.repeat_count;

	always_comb begin
		nxt = cur;
		case (mode)
			MODE_TICK: begin
				nxt.timer = timer_inc;
				if (cur.running) begin
					if (cur.on_phase) begin
						if (timer_inc > on_lim) begin
							nxt.timer    = '0;
							nxt.on_phase = 1'b0;
							// An endless pattern never uses up its repeats.
							if (cur.repeat_count != ENDLESS) begin
								nxt.repeat_count = reps_dec;
								if (reps_dec == '0) begin
									nxt.running = 1'b0;
								end
							end
						end
					end else if (timer_inc > off_lim) begin
						nxt.timer    = '0;
						nxt.on_phase = 1'b1;
					end
				end
			end
			MODE_START: begin
				nxt.pattern_index = pattern;
				nxt.running       = 1'b1;
				nxt.repeat_count  = preset_reps(kind, pattern);
				nxt.timer         = '0;
				nxt.on_phase      = (kind == KIND_VIBRATOR);
			end
			MODE_STOP: begin
				nxt.on_phase = 1'b0;
				nxt.running  = 1'b0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/blink_pattern_generator.sv
// Top level of the blink pattern generator: state registers, result register and handshakes.
// The result for a request is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken; the single result register is refilled as it drains.
// Reset: arst_n clears the pattern state, the output kind and the result valid flag at once.
`default_nettype none
`include "blink_pattern_generator_assert.svh"

module blink_pattern_generator (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	bpg_cmd_if.sink    cmd,
	bpg_res_if.source  res
);
	import bpg_pkg::*;

	// Pattern state, the output kind register and the result register.
	state_t     st_q;
	state_t     st_next;
	logic       output_kind_q;
	logic       res_valid_q;
	logic       pin_level_q;
	logic       busy_q;
	logic [7:0] reps_q;
	logic       cmd_take;

	// A new request is taken whenever the result register is empty or is being
	// drained in this same cycle; a waiting result that is not taken stalls the input side.
	assign cmd.ready = !res_valid_q || res.ready;
	assign cmd_take  = cmd.valid && cmd.ready;

	// The whole update for one request is a short piece of logic in the step unit.
	bpg_step u_step (
		.cur     (st_q),
		.mode    (cmd.mode),
		.pattern (cmd.pattern),
		.kind    (output_kind_q),
		.nxt     (st_next)
	);

	// The output kind is rewritten whenever the write enable is high. A running
	// pattern carries on under the new kind, which changes its timings and pin polarity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_kind_q <= KIND_VIBRATOR;
		end else if (cfg_we) begin
			output_kind_q <= cfg_wdata;
		end
	end

	// State advances only on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (cmd_take) begin
			st_q <= st_next;
		end
	end

	// The result valid flag is set by an accepted request and cleared when the
	// result is taken without a new one arriving behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// The result payload reports the state after the request. The LED pin is
	// active low, so its level is the inverse of the on phase.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			pin_level_q <= (output_kind_q == KIND_LED) ? !st_next.on_phase : st_next.on_phase;
			busy_q      <= st_next.running;
			reps_q      <= st_next.repeat_count;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.pin_level    = pin_level_q;
	assign res.busy_res     = busy_q;
	assign res.repeats_left = reps_q;

	// A stopped or finished pattern always rests in the off phase.
	`BPG_ASSERT_ALWAYS(a_idle_is_off, st_q.running || !st_q.on_phase)
	// Every accepted request leaves a result waiting in the next cycle.
	`BPG_ASSERT_NEXT(a_take_gives_result, cmd_take, res_valid_q)
	// A start request clears the phase timer and sets the pattern running.
	`BPG_ASSERT_NEXT(a_start_loads, cmd_take && cmd.mode == MODE_START,
		st_q.timer == '0 && st_q.running)
	// An endless pattern keeps its repeat count through ticks and stops.
	`BPG_ASSERT_NEXT(a_endless_kept,
		cmd_take && cmd.mode != MODE_START && st_q.repeat_count == ENDLESS,
		st_q.repeat_count == ENDLESS)

endmodule

`default_nettype wire

FILE: verif/tb_blink_pattern_generator.sv
// Self-checking testbench of the blink pattern generator: directed script, a long run and random requests.
`timescale 1ns / 1ps

module tb_blink_pattern_generator;
	import bpg_pkg::*;

	// The package has no name for the fourth mode encoding, which the block must ignore.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Silence on both channels for this many cycles means the block has hung.
	// The deliberate receiver hold-off below is well inside it.
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int HOLD_OFF_AT     = 500;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_REQUESTS = 1000;

	// What the block reports after every request.
	typedef struct packed {
		logic       pin_level;
		logic       busy;
		logic [7:0] repeats_left;
	} pin_report_t;

	// Our own copy of the pattern state, kept in step with the block.
	typedef struct packed {
		logic [10:0] timer_ms;
		logic        lit;
		logic        active;
		logic [7:0]  bursts_left;
		logic [1:0]  preset;
	} burst_state_t;

	typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  mode;
		logic [1:0]  pattern;
		logic        cfg_value;
		logic        checked;
		pin_report_t want;
	} script_row_t;

	// Directed opening. Rows with checked set carry a result that is obvious from the
	// specification (after reset, preset loads, stop keeping the count, LED inversion);
	// the others are left to the predictor.
	localparam int SCRIPT_ROWS = 24;
	localparam script_row_t DIRECTED_SCRIPT [SCRIPT_ROWS] = '{
		'{ROW_REQUEST, MODE_TICK,   2'd0, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd0}},
		'{ROW_REQUEST, MODE_UNUSED, 2'd3, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd0}},
		'{ROW_REQUEST, MODE_STOP,   2'd1, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd0}},
		'{ROW_REQUEST, MODE_START,  2'd0, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd255}},
		'{ROW_REQUEST, MODE_TICK,   2'd2, 1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{ROW_REQUEST, MODE_START,  2'd3, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd180}},
		'{ROW_REQUEST, MODE_START,  2'd1, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd1}},
		'{ROW_REQUEST, MODE_START,  2'd2, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd2}},
		'{ROW_REQUEST, MODE_STOP,   2'd0, 1'b0, 1'b1, '{1'b0, 1'b0, 8'd2}},
		'{ROW_REQUEST, MODE_TICK,   2'd3, 1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{ROW_CONFIG,  MODE_TICK,   2'd0, 1'b1, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{ROW_REQUEST, MODE_TICK,   2'd0, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd2}},
		'{ROW_REQUEST, MODE_START,  2'd0, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd255}},
		'{ROW_REQUEST, MODE_START,  2'd1, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd2}},
		'{ROW_REQUEST, MODE_START,  2'd2, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd10}},
		'{ROW_REQUEST, MODE_START,  2'd3, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd180}},
		'{ROW_REQUEST, MODE_UNUSED, 2'd2, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd180}},
		'{ROW_REQUEST, MODE_TICK,   2'd1, 1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{ROW_REQUEST, MODE_STOP,   2'd3, 1'b0, 1'b1, '{1'b1, 1'b0, 8'd180}},
		'{ROW_CONFIG,  MODE_TICK,   2'd0, 1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{ROW_REQUEST, MODE_START,  2'd3, 1'b0, 1'b1, '{1'b1, 1'b1, 8'd180}},
		'{ROW_CONFIG,  MODE_TICK,   2'd0, 1'b1, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{ROW_REQUEST, MODE_TICK,   2'd0, 1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}},
		'{ROW_REQUEST, MODE_UNUSED, 2'd1, 1'b0, 1'b0, '{1'b0, 1'b0, 8'd0}}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	bpg_cmd_if cmd_ch ();
	bpg_res_if res_ch ();

	blink_pattern_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state, the output kind register as last written, and the results
	// still owed by the block, oldest first.
	burst_state_t burst;
	logic         led_kind;
	pin_report_t  pending_reports [$];

	int mismatch_count = 0;
	int requests_sent  = 0;
	int reports_seen   = 0;
	int kind_writes    = 0;
	int phase_flips    = 0;
	int runs_finished  = 0;
	int quiet_cycles   = 0;
	int send_calm      = 0;
	int sink_calm      = 0;

	// Preset timings. The tables are indexed by output kind and stored preset.
	function automatic logic [10:0] lit_span_ms(input logic kind, input logic [1:0] idx);
		case ({kind, idx})
			3'b000, 3'b100: return 11'd25;
			3'b001:         return 11'd700;
			3'b010:         return 11'd400;
			3'b101, 3'b110: return 11'd175;
			default:        return 11'd100;
		endcase
	endfunction

	function automatic logic [10:0] dark_span_ms(input logic kind, input logic [1:0] idx);
		case ({kind, idx})
			3'b000, 3'b100: return 11'd1975;
			3'b001:         return 11'd300;
			3'b010:         return 11'd250;
			3'b101, 3'b110: return 11'd200;
			default:        return 11'd900;
		endcase
	endfunction

	function automatic logic [7:0] burst_budget(input logic kind, input logic [1:0] idx);
		case ({kind, idx})
			3'b000, 3'b100: return 8'd255;
			3'b001:         return 8'd1;
			3'b010:         return 8'd2;
			3'b101:         return 8'd2;
			3'b110:         return 8'd10;
			default:        return 8'd180;
		endcase
	endfunction

	// Applies one accepted request to the predicted state and returns what the block
	// must report. A tick always moves the timer (saturating), even when idle; only a
	// running pattern compares it against the current phase length, and the length is
	// taken from the stored preset under whatever output kind is set now.
	function automatic pin_report_t advance_pattern(input logic [1:0] mode,
		input logic [1:0] pat);
		pin_report_t r;
		case (mode)
			MODE_TICK: begin
				if (burst.timer_ms != TIMER_MAX)
					burst.timer_ms++;
				if (burst.active) begin
					if (burst.lit) begin
						if (burst.timer_ms > lit_span_ms(led_kind, burst.preset)) begin
							burst.timer_ms = '0;
							burst.lit      = 1'b0;
							phase_flips++;
							// Each finished on burst uses one repeat unless endless.
							if (burst.bursts_left != ENDLESS) begin
								if (burst.bursts_left != 8'd0)
									burst.bursts_left--;
								if (burst.bursts_left == 8'd0) begin
									burst.active = 1'b0;
									runs_finished++;
								end
							end
						end
					end else if (burst.timer_ms > dark_span_ms(led_kind, burst.preset)) begin
						burst.timer_ms = '0;
						burst.lit      = 1'b1;
						phase_flips++;
					end
				end
			end
			MODE_START: begin
				burst.preset      = pat;
				burst.active      = 1'b1;
				burst.bursts_left = burst_budget(led_kind, pat);
				burst.timer_ms    = '0;
				// The vibrator starts buzzing at once; the LED starts dark.
				burst.lit         = (led_kind == KIND_VIBRATOR);
			end
			MODE_STOP: begin
				// The repeat count and the timer are left as they were.
				burst.lit    = 1'b0;
				burst.active = 1'b0;
			end
			default: begin
			end
		endcase
		r.pin_level    = (led_kind == KIND_LED) ? ~burst.lit : burst.lit;
		r.busy         = burst.active;
		r.repeats_left = burst.bursts_left;
		return r;
	endfunction

	// Per-request wait for either side, with occasional stretches of back-to-back traffic.
	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// Offers one request and waits for the block to take it. Valid is left high on
	// return; the next call either replaces the payload in the same step or lowers valid
	// for its gap, so valid never gets two assignments in one step.
	task automatic offer_request(input logic [1:0] mode, input logic [1:0] pat,
		input logic checked, input pin_report_t want);
		int          gap;
		pin_report_t predicted;
		gap = draw_gap(send_calm);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.mode    <= mode;
		cmd_ch.pattern <= pat;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = advance_pattern(mode, pat);
		pending_reports.push_back(checked ? want : predicted);
		requests_sent++;
	endtask

	// Withdraws the request channel and waits until every result owed has been taken.
	// Must be called in the step in which the last request was accepted.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// The output kind is only rewritten with no request in flight. A running pattern
	// carries on under the new kind, which changes both its timings and the pin polarity.
	task automatic write_output_kind(input logic value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		led_kind = value;
		kind_writes++;
	endtask

	task automatic tick_request();
		offer_request(MODE_TICK, 2'($urandom_range(0, 3)), 1'b0, '0);
	endtask

	// Request side: reset, directed script, a long run, then random scenarios.
	initial begin : request_source
		int directed_count;
		int random_base;
		int n;
		int guard;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= 1'b0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.mode    <= MODE_TICK;
		cmd_ch.pattern <= 2'd0;
		burst    = '0;
		led_kind = KIND_VIBRATOR;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			if (DIRECTED_SCRIPT[i].kind == ROW_CONFIG)
				write_output_kind(DIRECTED_SCRIPT[i].cfg_value);
			else
				offer_request(DIRECTED_SCRIPT[i].mode, DIRECTED_SCRIPT[i].pattern,
					DIRECTED_SCRIPT[i].checked, DIRECTED_SCRIPT[i].want);
		end
		directed_count = requests_sent;

		// Preset 1 (one on burst for the vibrator, two for the LED) run to its natural end under a random kind,
		// so that the last on burst is seen to send the block idle.
		random_base = requests_sent;
		write_output_kind(1'($urandom_range(0, 1)));
		offer_request(MODE_START, 2'd1, 1'b0, '0);
		guard = 0;
		while (burst.active && guard < 1200) begin
			tick_request();
			guard++;
		end

		// Mostly well-formed scenarios (a start followed by a run of ticks long enough
		// to cross phase boundaries), with ticks carried on after a kind change, and
		// some fully random noise including the unused mode.
		while (requests_sent - random_base < RANDOM_REQUESTS) begin
			if ($urandom_range(0, 2) == 0)
				write_output_kind(1'($urandom_range(0, 1)));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					offer_request(MODE_START, 2'($urandom_range(0, 3)), 1'b0, '0);
					n = $urandom_range(20, 260);
					repeat (n) tick_request();
					if ($urandom_range(0, 3) == 0)
						offer_request(MODE_STOP, 2'($urandom_range(0, 3)), 1'b0, '0);
				end
				6, 7: begin
					n = $urandom_range(20, 200);
					repeat (n) tick_request();
				end
				default: begin
					n = $urandom_range(4, 24);
					repeat (n)
						offer_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
							1'b0, '0);
				end
			endcase
		end

		settle();
		repeat (8) @(posedge clk);

		$display("Ran %0d requests: %0d directed, %0d in the long run and random scenarios.",
			requests_sent, directed_count, requests_sent - random_base);
		$display("Saw %0d phase changes, %0d patterns run to completion, %0d kind writes.",
			phase_flips, runs_finished, kind_writes);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Result side: takes each result after a random wait and checks it against the oldest
	// expectation. Once, well into the run, it holds off for a long stretch so that the
	// result register fills and the block has to stall its request input.
	initial begin : result_sink
		int          gap;
		pin_report_t want;

		res_ch.ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (reports_seen == HOLD_OFF_AT)
				gap = HOLD_OFF_CYCLES;
			else
				gap = draw_gap(sink_calm);
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			reports_seen++;
			if (pending_reports.size() == 0) begin
				$error("result taken with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				if (res_ch.pin_level !== want.pin_level) begin
					$error("pin_level: expected %0b, got %0b", want.pin_level,
						res_ch.pin_level);
					mismatch_count++;
				end
				if (res_ch.busy_res !== want.busy) begin
					$error("busy_res: expected %0b, got %0b", want.busy, res_ch.busy_res);
					mismatch_count++;
				end
				if (res_ch.repeats_left !== want.repeats_left) begin
					$error("repeats_left: expected %0d, got %0d", want.repeats_left,
						res_ch.repeats_left);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: any handshake on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timed out after %0d cycles without a handshake.", quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
